// File: hw/rtl/pab_pkg.sv
`timescale 1ns / 1ps

package pab_pkg;

    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT_DEF = 256;
    localparam int CHANNELS_DEF   = 4;

    localparam int SAMPLE_W = 16;
    localparam int SUM_W    = 32;
    localparam int COUNT_W  = 16;
    localparam int CFG_W    = 9;
    localparam int CFG_IDX_W = 4;

    typedef enum logic [2:0] {
        CMD_ADD      = 3'd0,
        CMD_SET      = 3'd1,
        CMD_FILL_SET = 3'd2,
        CMD_FILL_ADD = 3'd3,
        CMD_READ     = 3'd4,
        CMD_CLEAR    = 3'd5
    } cmd_t;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 4'd1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_MODIFY,
        ST_DIV_LOAD,
        ST_DIV_STEP,
        ST_DIV_END,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [2:0]                 cmd;
        logic [7:0]                 pos_x;
        logic [7:0]                 pos_y;
        logic signed [SAMPLE_W-1:0] sample_red;
        logic signed [SAMPLE_W-1:0] sample_green;
        logic signed [SAMPLE_W-1:0] sample_blue;
        logic signed [SAMPLE_W-1:0] sample_alpha;
    } in_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] avg_red;
        logic signed [SAMPLE_W-1:0] avg_green;
        logic signed [SAMPLE_W-1:0] avg_blue;
        logic signed [SAMPLE_W-1:0] avg_alpha;
        logic [COUNT_W-1:0]         sample_count;
        logic                       bad_position;
    } out_t;

endpackage

// File: hw/rtl/pixel_accumulation_buffer_top.sv
`timescale 1ns / 1ps

// Channel   Ports                         Direction  Beat
// input     s_valid / s_ready / s_data    in         one command (pab_pkg::in_t)
// result    m_valid / m_ready / m_data    out        one read result (pab_pkg::out_t)
// config    cfg_valid / cfg_ready         in         cfg_index, cfg_data
//
// Add / set: accept, memory read, write back; one memory port pair.
// Fill set / fill add: a memory read and a write back for each of the width*height pixels.
// Read: memory read, then a divide per channel (skipped outside the image); one shared 32/16 bit-serial divider.
// Clear, and the pass after reset: all MAX_WIDTH*MAX_HEIGHT words (65536), one word a cycle.
// s_ready is low while a command runs; a result held by a stalled m_ready
// does not block new commands, only the next read result.

module pixel_accumulation_buffer_top #(
    parameter int MAX_WIDTH  = pab_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = pab_pkg::MAX_HEIGHT_DEF,
    parameter int CHANNELS   = pab_pkg::CHANNELS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  pab_pkg::in_t              s_data,
    output logic                      m_valid,
    input  logic                      m_ready,
    output pab_pkg::out_t             m_data,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [pab_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pab_pkg::CFG_W-1:0] cfg_data
);
    import pab_pkg::*;

    localparam int PIX  = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW   = (PIX > 1) ? $clog2(PIX) : 1;
    localparam int DW   = ($clog2(MAX_WIDTH + 1) > CFG_W) ? $clog2(MAX_WIDTH + 1) : CFG_W;
    localparam int HW   = ($clog2(MAX_HEIGHT + 1) > CFG_W) ? $clog2(MAX_HEIGHT + 1) : CFG_W;
    localparam int LW   = DW + HW;
    localparam int PW   = DW + 9;
    localparam int MW   = CHANNELS * SUM_W + COUNT_W;
    localparam int CHW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // control registers
    state_t             state_reg, state_next;
    logic [CFG_W-1:0]   width_reg, height_reg;
    in_t                in_reg;
    logic [AW-1:0]      addr_reg;
    logic [LW-1:0]      lim_reg;
    logic               bad_reg;
    logic [CHW-1:0]     ch_reg;
    logic [4:0]         step_reg;
    logic               m_valid_reg;
    out_t               m_data_reg;

    // datapath registers
    logic [MW-1:0]      rdata_reg;
    logic [SUM_W-1:0]   quo_reg;
    logic [COUNT_W-1:0] rem_reg;
    logic [COUNT_W-1:0] den_reg;
    logic               neg_reg;
    logic [SAMPLE_W-1:0] avg_reg [4];

    logic [MW-1:0]      mem [PIX];

    // effective image size
    logic [DW-1:0] w_eff;
    logic [HW-1:0] h_eff;
    logic          in_image;
    logic [PW-1:0] pix_full;
    logic          s_fire;

    always_comb begin
        if (width_reg == '0) begin
            w_eff = DW'(1);
        end else if (DW'(width_reg) > DW'(MAX_WIDTH)) begin
            w_eff = DW'(MAX_WIDTH);
        end else begin
            w_eff = DW'(width_reg);
        end
        if (height_reg == '0) begin
            h_eff = HW'(1);
        end else if (HW'(height_reg) > HW'(MAX_HEIGHT)) begin
            h_eff = HW'(MAX_HEIGHT);
        end else begin
            h_eff = HW'(height_reg);
        end
    end

    assign in_image = (DW'(s_data.pos_x) < w_eff) && (HW'(s_data.pos_y) < h_eff);
    assign pix_full = PW'(s_data.pos_y) * PW'(w_eff) + PW'(s_data.pos_x);
    assign s_fire   = s_valid && s_ready;

    // samples by channel
    logic signed [SAMPLE_W-1:0] smp [4];
    assign smp[0] = in_reg.sample_red;
    assign smp[1] = in_reg.sample_green;
    assign smp[2] = in_reg.sample_blue;
    assign smp[3] = in_reg.sample_alpha;

    // read-modify-write data
    logic               accum;
    logic [MW-1:0]      wdata;
    logic [COUNT_W-1:0] cnt_old;

    assign accum   = (in_reg.cmd == CMD_ADD) || (in_reg.cmd == CMD_FILL_ADD);
    assign cnt_old = rdata_reg[CHANNELS*SUM_W +: COUNT_W];

    always_comb begin
        logic [SUM_W:0] s33;
        logic [SUM_W-1:0] old;
        wdata = '0;
        for (int c = 0; c < CHANNELS; c++) begin
            old = rdata_reg[c*SUM_W +: SUM_W];
            s33 = {old[SUM_W-1], old} + (SUM_W+1)'(smp[c]);
            if (!accum) begin
                wdata[c*SUM_W +: SUM_W] = SUM_W'(smp[c]);
            end else if (s33[SUM_W] != s33[SUM_W-1]) begin
                wdata[c*SUM_W +: SUM_W] = s33[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                                     : {1'b0, {(SUM_W-1){1'b1}}};
            end else begin
                wdata[c*SUM_W +: SUM_W] = s33[SUM_W-1:0];
            end
        end
        if (!accum) begin
            wdata[CHANNELS*SUM_W +: COUNT_W] = COUNT_W'(1);
        end else if (cnt_old == '1) begin
            wdata[CHANNELS*SUM_W +: COUNT_W] = cnt_old;
        end else begin
            wdata[CHANNELS*SUM_W +: COUNT_W] = cnt_old + COUNT_W'(1);
        end
    end

    // divider step
    logic [COUNT_W:0]   trial;
    logic [COUNT_W:0]   diff;
    logic               ge;
    logic [SUM_W-1:0]   div_in;
    logic [SAMPLE_W-1:0] avg_val;

    assign trial  = {rem_reg, quo_reg[SUM_W-1]};
    assign diff   = trial - {1'b0, den_reg};
    assign ge     = trial >= {1'b0, den_reg};
    assign div_in = rdata_reg[ch_reg*SUM_W +: SUM_W];

    always_comb begin
        if (neg_reg) begin
            avg_val = (quo_reg > SUM_W'(32768)) ? 16'h8000 : SAMPLE_W'(-quo_reg);
        end else begin
            avg_val = (quo_reg > SUM_W'(32767)) ? 16'h7FFF : quo_reg[SAMPLE_W-1:0];
        end
    end

    // next state
    logic sweep_last;
    logic clear_last;
    assign sweep_last = (LW'(addr_reg) + LW'(1)) == lim_reg;
    assign clear_last = addr_reg == AW'(PIX - 1);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clear_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_fire) begin
                    case (s_data.cmd)
                        CMD_ADD, CMD_SET:           state_next = in_image ? ST_READ : ST_IDLE;
                        CMD_FILL_SET, CMD_FILL_ADD: state_next = ST_READ;
                        CMD_READ:                   state_next = in_image ? ST_READ : ST_DONE;
                        CMD_CLEAR:                  state_next = ST_CLEAR;
                        default:                    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_READ: begin
                state_next = ST_MODIFY;
            end
            ST_MODIFY: begin
                if (in_reg.cmd == CMD_READ) begin
                    state_next = ST_DIV_LOAD;
                end else if ((in_reg.cmd == CMD_FILL_SET || in_reg.cmd == CMD_FILL_ADD)
                             && !sweep_last) begin
                    state_next = ST_READ;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIV_LOAD: begin
                state_next = ST_DIV_STEP;
            end
            ST_DIV_STEP: begin
                if (step_reg == 5'd31) state_next = ST_DIV_END;
            end
            ST_DIV_END: begin
                state_next = (ch_reg == CHW'(CHANNELS - 1)) ? ST_DONE : ST_DIV_LOAD;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    logic          mem_we;
    logic [MW-1:0] mem_wdata;

    always_comb begin
        s_ready   = (state_reg == ST_IDLE);
        cfg_ready = 1'b1;
        mem_we    = (state_reg == ST_CLEAR) ||
                    (state_reg == ST_MODIFY && in_reg.cmd != CMD_READ);
        mem_wdata = (state_reg == ST_CLEAR) ? '0 : wdata;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // memory: one write and one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[addr_reg] <= mem_wdata;
        end
        if (state_reg == ST_READ) begin
            rdata_reg <= mem[addr_reg];
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            width_reg   <= CFG_W'(256);
            height_reg  <= CFG_W'(256);
            addr_reg    <= '0;
            m_valid_reg <= 1'b0;
            ch_reg      <= '0;
            step_reg    <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_IMAGE_WIDTH)  width_reg  <= cfg_data;
                if (cfg_index == REG_IMAGE_HEIGHT) height_reg <= cfg_data;
            end
            // result valid: load a new beat or retire the taken one
            if (state_reg == ST_DONE && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR: begin
                    addr_reg <= clear_last ? '0 : addr_reg + AW'(1);
                end
                ST_IDLE: begin
                    ch_reg <= '0;
                    if (s_fire) begin
                        if (s_data.cmd == CMD_ADD || s_data.cmd == CMD_SET ||
                            s_data.cmd == CMD_READ) begin
                            addr_reg <= in_image ? pix_full[AW-1:0] : '0;
                        end else begin
                            addr_reg <= '0;
                        end
                    end
                end
                ST_MODIFY: begin
                    if (state_next == ST_READ) addr_reg <= addr_reg + AW'(1);
                end
                ST_DIV_LOAD: begin
                    step_reg <= '0;
                end
                ST_DIV_STEP: begin
                    step_reg <= step_reg + 5'd1;
                end
                ST_DIV_END: begin
                    ch_reg <= ch_reg + CHW'(1);
                end
                default: begin
                end
            endcase
        end
    end

    // payload and divider datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    in_reg  <= s_data;
                    bad_reg <= !in_image;
                    lim_reg <= LW'(w_eff) * LW'(h_eff);
                    for (int c = 0; c < 4; c++) avg_reg[c] <= '0;
                end
            end
            ST_DIV_LOAD: begin
                neg_reg <= div_in[SUM_W-1];
                quo_reg <= div_in[SUM_W-1] ? -div_in : div_in;
                rem_reg <= '0;
                den_reg <= (cnt_old == '0) ? COUNT_W'(1) : cnt_old;
            end
            ST_DIV_STEP: begin
                rem_reg <= ge ? diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
                quo_reg <= {quo_reg[SUM_W-2:0], ge};
            end
            ST_DIV_END: begin
                avg_reg[ch_reg] <= avg_val;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_data_reg.avg_red      <= avg_reg[0];
                    m_data_reg.avg_green    <= avg_reg[1];
                    m_data_reg.avg_blue     <= avg_reg[2];
                    m_data_reg.avg_alpha    <= avg_reg[3];
                    m_data_reg.sample_count <= bad_reg ? '0 : cnt_old;
                    m_data_reg.bad_position <= bad_reg;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

// File: hw/rtl/pab_checker.sv
`timescale 1ns / 1ps

module pab_checker (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    input  logic          s_ready,
    input  pab_pkg::in_t  s_data,
    input  logic          m_valid,
    input  logic          m_ready,
    input  pab_pkg::out_t m_data
);
    import pab_pkg::*;

    // store is swept after reset before any command is taken
    a_reset_sweep: assert property (@(posedge aclk) !aresetn |=> !s_ready)
        else $error("input ready right after reset");

    // an accepted read beat always takes the block out of idle, so input ready drops
    a_read_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.cmd == CMD_READ) |=> !s_ready)
        else $error("ready held through a read");

    // an out-of-image result carries nothing but the flag
    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.bad_position) |->
        (m_data.avg_red == '0 && m_data.avg_green == '0 && m_data.avg_blue == '0 &&
         m_data.avg_alpha == '0 && m_data.sample_count == '0))
        else $error("bad position result with nonzero fields");

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("result changed under stall");

endmodule

bind pixel_accumulation_buffer_top pab_checker u_pab_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// File: verif/pixel_accumulation_buffer_top_tb.sv
`timescale 1ns / 1ps

module pixel_accumulation_buffer_top_tb;
    import pab_pkg::*;

    localparam int NUM_PIX     = MAX_WIDTH_DEF * MAX_HEIGHT_DEF;
    localparam int CYCLE_LIMIT = 4000000;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    in_t                  s_data = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    out_t                 m_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = REG_IMAGE_WIDTH;
    logic [CFG_W-1:0]     cfg_data = '0;

    // shadow image store
    int         sum_store [NUM_PIX*4];
    bit [15:0]  count_store [NUM_PIX];
    int unsigned width_reg = 256;
    int unsigned height_reg = 256;

    in_t   cmd_q [$];
    out_t  read_results_q [$];
    int    errors = 0;
    int    cycles = 0;
    bit    idle_en_s = 1'b1;
    bit    idle_en_m = 1'b1;

    pixel_accumulation_buffer_top i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic int unsigned clamp_dim(int unsigned v);
        if (v < 1) return 1;
        if (v > 256) return 256;
        return v;
    endfunction

    function automatic int sat_sum(int a, int b);
        longint s;
        s = longint'(a) + longint'(b);
        if (s > 64'sd2147483647) return 32'sh7fffffff;
        if (s < -64'sd2147483648) return 32'sh80000000;
        return int'(s);
    endfunction

    // one pixel write: accumulate or overwrite
    function automatic void update_pixel(int unsigned pix, int smp[4], bit accumulate);
        for (int c = 0; c < 4; c++)
            sum_store[pix*4+c] = accumulate ? sat_sum(sum_store[pix*4+c], smp[c]) : smp[c];
        if (accumulate) begin
            if (count_store[pix] != 16'hffff) count_store[pix]++;
        end else begin
            count_store[pix] = 16'd1;
        end
    endfunction

    // apply one accepted command to the shadow store, queue the read result
    function automatic void apply_command(in_t it);
        int unsigned w, h, pix;
        bit     in_image;
        int     smp[4];
        longint s, n, a;
        out_t   r;
        w = clamp_dim(width_reg);
        h = clamp_dim(height_reg);
        in_image = (it.pos_x < w) && (it.pos_y < h);
        pix = in_image ? it.pos_y * w + it.pos_x : 0;
        smp[0] = it.sample_red;
        smp[1] = it.sample_green;
        smp[2] = it.sample_blue;
        smp[3] = it.sample_alpha;
        case (it.cmd)
            CMD_ADD, CMD_SET: begin
                if (in_image) update_pixel(pix, smp, it.cmd == CMD_ADD);
            end
            CMD_FILL_SET, CMD_FILL_ADD: begin
                for (int unsigned p = 0; p < w*h; p++)
                    update_pixel(p, smp, it.cmd == CMD_FILL_ADD);
            end
            CMD_READ: begin
                r = '0;
                if (!in_image) begin
                    r.bad_position = 1'b1;
                end else begin
                    n = count_store[pix];
                    for (int c = 0; c < 4; c++) begin
                        s = sum_store[pix*4+c];
                        a = (n > 0) ? s / n : s;
                        if (a > 32767) a = 32767;
                        if (a < -32768) a = -32768;
                        case (c)
                            0: r.avg_red   = a[15:0];
                            1: r.avg_green = a[15:0];
                            2: r.avg_blue  = a[15:0];
                            default: r.avg_alpha = a[15:0];
                        endcase
                    end
                    r.sample_count = count_store[pix];
                end
                read_results_q.push_back(r);
            end
            CMD_CLEAR: begin
                for (int k = 0; k < NUM_PIX*4; k++) sum_store[k] = 0;
                for (int k = 0; k < NUM_PIX; k++) count_store[k] = '0;
            end
            default: ;
        endcase
    endfunction

    // input driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) apply_command(s_data);
            if (!s_valid || s_ready) begin
                if (cmd_q.size() > 0 && !(idle_en_s && $urandom_range(99) < 30)) begin
                    s_data  <= cmd_q.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and checker
    always @(posedge aclk) begin
        out_t exp_r;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (read_results_q.size() == 0) begin
                    $display("%0t: unexpected read result %h", $time, m_data);
                    errors++;
                end else begin
                    exp_r = read_results_q.pop_front();
                    if (m_data.avg_red !== exp_r.avg_red ||
                        m_data.avg_green !== exp_r.avg_green ||
                        m_data.avg_blue !== exp_r.avg_blue ||
                        m_data.avg_alpha !== exp_r.avg_alpha ||
                        m_data.sample_count !== exp_r.sample_count ||
                        m_data.bad_position !== exp_r.bad_position) begin
                        $display("%0t: read mismatch expected r%h g%h b%h a%h n%h bad%b",
                                 $time, exp_r.avg_red, exp_r.avg_green, exp_r.avg_blue,
                                 exp_r.avg_alpha, exp_r.sample_count, exp_r.bad_position);
                        $display("%0t:               actual   r%h g%h b%h a%h n%h bad%b",
                                 $time, m_data.avg_red, m_data.avg_green, m_data.avg_blue,
                                 m_data.avg_alpha, m_data.sample_count, m_data.bad_position);
                        errors++;
                    end
                end
            end
            m_ready <= !(idle_en_m && $urandom_range(99) < 30);
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'hffff;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic in_t make_cmd(logic [2:0] op, int x, int y);
        in_t it;
        it.cmd = op;
        it.pos_x = 8'(x);
        it.pos_y = 8'(y);
        it.sample_red = pick_sample();
        it.sample_green = pick_sample();
        it.sample_blue = pick_sample();
        it.sample_alpha = pick_sample();
        return it;
    endfunction

    // random mix: mostly in-image add/read traffic, some noise
    task automatic push_random(int n, bit fills_ok);
        int unsigned w, h, roll, x, y;
        logic [2:0] op;
        w = clamp_dim(width_reg);
        h = clamp_dim(height_reg);
        for (int i = 0; i < n; i++) begin
            roll = $urandom_range(99);
            if (roll < 40) op = CMD_ADD;
            else if (roll < 50) op = CMD_SET;
            else if (roll < 88) op = CMD_READ;
            else if (roll < 94 && fills_ok) op = ($urandom_range(1) ? CMD_FILL_ADD : CMD_FILL_SET);
            else if (roll < 97) op = 3'($urandom_range(7, 6));
            else op = CMD_READ;
            if ($urandom_range(99) < 80) begin
                x = $urandom_range(w-1);
                y = $urandom_range(h-1);
            end else begin
                x = $urandom_range(255);
                y = $urandom_range(255);
            end
            cmd_q.push_back(make_cmd(op, x, y));
        end
    endtask

    // wait until all commands are taken, results are in and the block is idle
    task automatic drain();
        int quiet;
        quiet = 0;
        while (quiet < 8) begin
            @(posedge aclk);
            #1;
            if (cmd_q.size() == 0 && !s_valid && read_results_q.size() == 0 && s_ready)
                quiet++;
            else
                quiet = 0;
        end
        repeat (200) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_W'(val);
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        if (idx == REG_IMAGE_WIDTH) width_reg = val & 9'h1ff;
        else height_reg = val & 9'h1ff;
        cfg_valid <= 1'b0;
    endtask

    task automatic new_shape(int unsigned w, int unsigned h);
        drain();
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: full-size image
        cmd_q.push_back(make_cmd(CMD_READ, 0, 0));
        cmd_q.push_back(make_cmd(CMD_SET, 255, 255));
        cmd_q.push_back(make_cmd(CMD_ADD, 255, 255));
        cmd_q.push_back(make_cmd(CMD_READ, 255, 255));
        cmd_q.push_back(make_cmd(CMD_FILL_SET, 0, 0));
        cmd_q.push_back(make_cmd(CMD_FILL_ADD, 0, 0));
        cmd_q.push_back(make_cmd(CMD_READ, 17, 200));
        cmd_q.push_back(make_cmd(CMD_CLEAR, 0, 0));
        cmd_q.push_back(make_cmd(CMD_READ, 255, 255));

        // directed: zero width acts as one, oversize height clamps
        new_shape(0, 511);
        cmd_q.push_back(make_cmd(CMD_SET, 0, 255));
        cmd_q.push_back(make_cmd(CMD_ADD, 1, 0));
        cmd_q.push_back(make_cmd(CMD_SET, 0, 0));
        cmd_q.push_back(make_cmd(CMD_READ, 0, 255));
        cmd_q.push_back(make_cmd(CMD_READ, 1, 0));
        cmd_q.push_back(make_cmd(CMD_READ, 255, 255));
        cmd_q.push_back(make_cmd(3'd6, 0, 0));
        cmd_q.push_back(make_cmd(3'd7, 0, 0));
        cmd_q.push_back(make_cmd(CMD_READ, 0, 0));

        // directed: single pixel
        new_shape(1, 0);
        cmd_q.push_back(make_cmd(CMD_FILL_ADD, 0, 0));
        cmd_q.push_back(make_cmd(CMD_ADD, 0, 0));
        cmd_q.push_back(make_cmd(CMD_ADD, 0, 1));
        cmd_q.push_back(make_cmd(CMD_READ, 0, 0));
        cmd_q.push_back(make_cmd(CMD_READ, 0, 1));

        // random phases over several shapes; no idling in the first one
        new_shape(8, 8);
        idle_en_s = 1'b0;
        idle_en_m = 1'b0;
        push_random(100, 1'b1);
        drain();
        idle_en_s = 1'b1;
        idle_en_m = 1'b1;
        push_random(150, 1'b1);
        new_shape(256, 3);
        push_random(150, 1'b1);
        new_shape(300, 300);
        push_random(120, 1'b0);
        cmd_q.push_back(make_cmd(CMD_CLEAR, 0, 0));
        push_random(60, 1'b0);
        new_shape(5, 256);
        push_random(120, 1'b1);
        new_shape(2, 1);
        push_random(60, 1'b1);

        drain();
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/pab_pkg.sv
hw/rtl/pixel_accumulation_buffer_top.sv
hw/rtl/pab_checker.sv
verif/pixel_accumulation_buffer_top_tb.sv
